/* rtl/dmc_pkg.sv */
// dmc_pkg: shared types and constants of the duplicate message cache
// no dependencies
package dmc_pkg;

  localparam int SRC_W           = 16;
  localparam int MSG_W           = 32;
  localparam int DEFAULT_ENTRIES = 32;

  // command codes of an input transfer
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // one message identity as stored in the ring
  typedef struct packed {
    logic [SRC_W-1:0] source;
    logic [MSG_W-1:0] message;
  } dmc_entry_t;

endpackage

/* rtl/dmc_if.sv */
// dmc_in_if, dmc_out_if: valid/ready channels of the duplicate message cache
// depends on dmc_pkg
interface dmc_in_if
  import dmc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             command;
  logic [SRC_W-1:0] source_node;
  logic [MSG_W-1:0] message_id;

  modport source (output valid, command, source_node, message_id, input ready);
  modport sink   (input valid, command, source_node, message_id, output ready);
endinterface

interface dmc_out_if;
  logic valid;
  logic ready;
  logic is_duplicate;

  modport source (output valid, is_duplicate, input ready);
  modport sink   (input valid, is_duplicate, output ready);
endinterface

/* rtl/dmc_ring.sv */
// dmc_ring: identity ring memory with one write port, one registered read port
// and the shared compare unit; depends on dmc_pkg
module dmc_ring
  import dmc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEFAULT_ENTRIES,
  parameter int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  dmc_entry_t       wr_data,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  input  dmc_entry_t       key,
  output logic             match
);

  dmc_entry_t mem_r [CACHE_ENTRIES];
  dmc_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata_r <= mem_r[rd_addr];
    end
  end

  // one 48-bit equality compare, reused for every entry of a scan
  assign match = (rdata_r == key);

endmodule

/* rtl/duplicate_message_cache.sv */
// duplicate_message_cache: top level of the flood routing duplicate cache
// depends on dmc_pkg, dmc_if (dmc_in_if, dmc_out_if) and dmc_ring
// usage
//   in_chan carries a command with a source node and a message id. an insert
//   writes the pair into the slot under the write pointer (the oldest slot
//   once the ring is full) in the cycle of its transfer and gives no result.
//   a lookup gives one result on out_chan: is_duplicate is 1 when the pair
//   matches any slot filled so far.
// throughput
//   back to back inserts are accepted every cycle while no lookup is in progress.
//   a lookup with n filled slots scans the ring memory one entry per cycle
//   through its single read port and shared comparator (an empty cache
//   skips the scan), and the next input is accepted in the cycle in which
//   the result appears on out_chan.
// reset
//   rst_n is synchronous, active low. it clears the write pointer, the fill
//   count, the sequencer and the output valid; the ring contents are not
//   cleared since only slots below the fill count are ever compared.
// stalls: the result sits in an output register until out_chan.ready takes
//   it; new items are accepted meanwhile, a later lookup waits at its end
module duplicate_message_cache
  import dmc_pkg::*;
#(
  parameter int CACHE_ENTRIES = DEFAULT_ENTRIES
) (
  input  logic      clk,
  input  logic      rst_n,
  dmc_in_if.sink    in_chan,
  dmc_out_if.source out_chan
);

  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic             hit_r, hit_nxt;
  dmc_entry_t       key_r, key_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_dup_r, out_dup_nxt;

  logic             in_xfer;
  logic             out_free;
  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             match;
  dmc_entry_t       in_entry;

  assign in_entry.source  = in_chan.source_node;
  assign in_entry.message = in_chan.message_id;

  assign in_chan.ready = (state_r == S_IDLE);
  assign in_xfer       = in_chan.valid && in_chan.ready;
  assign wr_en         = in_xfer && (in_chan.command == CMD_INSERT);

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.is_duplicate = out_dup_r;

  always_comb begin
    state_nxt     = state_r;
    wr_ptr_nxt    = wr_ptr_r;
    fill_nxt      = fill_r;
    scan_idx_nxt  = scan_idx_r;
    hit_nxt       = hit_r;
    key_nxt       = key_r;
    out_valid_nxt = out_valid_r;
    out_dup_nxt   = out_dup_r;
    rd_en         = 1'b0;
    rd_addr       = '0;

    // result taken by the receiver
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_chan.command == CMD_INSERT) begin
            // write pointer wraps after the last slot, fill count saturates
            wr_ptr_nxt = (wr_ptr_r == IDX_W'(CACHE_ENTRIES - 1)) ? '0 : wr_ptr_r + 1'b1;
            if (fill_r != CNT_W'(CACHE_ENTRIES)) begin
              fill_nxt = fill_r + 1'b1;
            end
          end else begin
            key_nxt = in_entry;
            hit_nxt = 1'b0;
            if (fill_r == '0) begin
              state_nxt = S_HOLD;
            end else begin
              // first read goes out with the transfer
              rd_en        = 1'b1;
              rd_addr      = '0;
              scan_idx_nxt = CNT_W'(1);
              state_nxt    = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        // compare the entry read last cycle, issue the next read
        hit_nxt = hit_r | match;
        if (scan_idx_r < fill_r) begin
          rd_en        = 1'b1;
          rd_addr      = scan_idx_r[IDX_W-1:0];
          scan_idx_nxt = scan_idx_r + 1'b1;
        end else begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_dup_nxt   = hit_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_ptr_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_ptr_r    <= wr_ptr_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk) begin
    scan_idx_r <= scan_idx_nxt;
    hit_r      <= hit_nxt;
    key_r      <= key_nxt;
    out_dup_r  <= out_dup_nxt;
  end

  dmc_ring #(
    .CACHE_ENTRIES (CACHE_ENTRIES),
    .IDX_W         (IDX_W)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_ptr_r),
    .wr_data (in_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .key     (key_r),
    .match   (match)
  );

endmodule
